>>> src/ors_pkg.sv
`default_nettype none
package ors_pkg;

    localparam int ROM_BITS_DEFAULT = 64;
    localparam int QUEUE_DEPTH      = 2;

    localparam int ID_W  = 64;
    localparam int ND_W  = 7;
    localparam int LD_W  = 8;

    localparam logic [LD_W-1:0] FIRST_PASS_MARK = 8'hFF;

    localparam logic [1:0] CMD_FIRST = 2'd0;
    localparam logic [1:0] CMD_NEXT  = 2'd1;
    localparam logic [1:0] CMD_PAIR  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_DONE        = 3'd1,
        ST_DATA_ERR    = 3'd2,
        ST_NO_PRESENCE = 3'd3,
        ST_IGNORED     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_START_FIRST,
        OP_START_NEXT,
        OP_NO_PRESENCE,
        OP_BIT_ZERO,
        OP_BIT_ONE,
        OP_BIT_BRANCH,
        OP_BIT_ERROR,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       presence;
        logic       true_bit;
        logic       complement_bit;
    } ors_in_t;

    typedef struct packed {
        logic            write_bit;
        status_t         status;
        logic [ID_W-1:0] rom_identifier;
        logic [ND_W-1:0] next_discrepancy;
        logic            search_finished;
    } ors_out_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ors_qwr_t;

endpackage
`default_nettype wire

>>> src/ors_front.sv
`default_nettype none
module ors_front (
    input  wire logic             push,
    input  wire logic             full,
    input  wire ors_pkg::ors_in_t item,
    output ors_pkg::ors_qwr_t     wr
);
    import ors_pkg::*;

    op_t op;

    always_comb
    begin
        case (item.cmd)
            CMD_FIRST: op = item.presence ? OP_START_FIRST : OP_NO_PRESENCE;
            CMD_NEXT:  op = item.presence ? OP_START_NEXT : OP_NO_PRESENCE;
            CMD_PAIR:
            begin
                case ({item.true_bit, item.complement_bit})
                    2'b00:   op = OP_BIT_BRANCH;
                    2'b01:   op = OP_BIT_ZERO;
                    2'b10:   op = OP_BIT_ONE;
                    default: op = OP_BIT_ERROR;
                endcase
            end
            default:   op = OP_IGNORE;
        endcase
    end

    assign wr.valid = push && !full;
    assign wr.op    = op;

endmodule
`default_nettype wire

>>> src/ors_queue.sv
`default_nettype none
module ors_queue #(
    parameter int DEPTH = ors_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ors_pkg::ors_qwr_t wr,
    input  wire logic              rd_en,
    output logic                   full,
    output logic                   empty,
    output ors_pkg::op_t           rd_op
);
    import ors_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rd_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr.valid, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= wr.op;
        end
    end

endmodule
`default_nettype wire

>>> src/ors_back.sv
`default_nettype none
module ors_back #(
    parameter int ROM_BITS = ors_pkg::ROM_BITS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire ors_pkg::op_t  q_op,
    output logic               q_rd,
    input  wire logic          pop,
    output logic               empty,
    output ors_pkg::ors_out_t  result
);
    import ors_pkg::*;

    localparam int POS_W = $clog2(ROM_BITS + 1);
    localparam int IDX_W = $clog2(ROM_BITS);

    logic [POS_W-1:0]    bit_pos_reg, bit_pos_next;
    logic [ROM_BITS-1:0] found_id_reg, found_id_next;
    logic [LD_W-1:0]     last_disc_reg, last_disc_next;
    logic [POS_W-1:0]    pend_disc_reg, pend_disc_next;
    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    ors_out_t            result_reg, result_next;

    logic [IDX_W-1:0] k_idx;
    logic [POS_W-1:0] pos;
    logic [LD_W-1:0]  pos_ext;
    logic             dir_bit;
    logic             take;

    assign take    = !q_empty && (!out_valid_reg || pop);
    assign q_rd    = take;
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    assign k_idx   = bit_pos_reg[IDX_W-1:0];
    assign pos     = POS_W'(ROM_BITS) - bit_pos_reg;
    assign pos_ext = LD_W'(pos);

    always_comb
    begin
        bit_pos_next   = bit_pos_reg;
        found_id_next  = found_id_reg;
        last_disc_next = last_disc_reg;
        pend_disc_next = pend_disc_reg;
        active_next    = active_reg;
        dir_bit        = 1'b0;

        result_next.write_bit        = 1'b0;
        result_next.status           = ST_IGNORED;
        result_next.rom_identifier   = '0;
        result_next.next_discrepancy = '0;
        result_next.search_finished  = 1'b0;

        case (q_op)
            OP_START_FIRST, OP_START_NEXT:
            begin
                if (q_op == OP_START_FIRST)
                begin
                    last_disc_next = FIRST_PASS_MARK;
                end
                bit_pos_next       = '0;
                pend_disc_next     = '0;
                active_next        = 1'b1;
                result_next.status = ST_OK;
            end
            OP_NO_PRESENCE:
            begin
                active_next        = 1'b0;
                result_next.status = ST_NO_PRESENCE;
            end
            OP_BIT_ERROR:
            begin
                if (active_reg)
                begin
                    active_next        = 1'b0;
                    result_next.status = ST_DATA_ERR;
                end
            end
            OP_BIT_ZERO, OP_BIT_ONE, OP_BIT_BRANCH:
            begin
                if (active_reg)
                begin
                    if (q_op == OP_BIT_ONE)
                    begin
                        dir_bit = 1'b1;
                    end
                    else if (q_op == OP_BIT_BRANCH)
                    begin
                        if ((last_disc_reg > pos_ext) ||
                            (found_id_reg[k_idx] && (last_disc_reg != pos_ext)))
                        begin
                            dir_bit        = 1'b1;
                            pend_disc_next = pos;
                        end
                    end
                    found_id_next[k_idx]  = dir_bit;
                    bit_pos_next          = bit_pos_reg + 1'b1;
                    result_next.write_bit = dir_bit;
                    if (bit_pos_reg == POS_W'(ROM_BITS - 1))
                    begin
                        active_next                  = 1'b0;
                        last_disc_next               = LD_W'(pend_disc_next);
                        result_next.status           = ST_DONE;
                        result_next.rom_identifier   = ID_W'(found_id_next);
                        result_next.next_discrepancy = ND_W'(pend_disc_next);
                        result_next.search_finished  = (pend_disc_next == '0);
                    end
                    else
                    begin
                        result_next.status = ST_OK;
                    end
                end
            end
            default:
            begin
                result_next.status = ST_IGNORED;
            end
        endcase

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg   <= '0;
            found_id_reg  <= '0;
            last_disc_reg <= FIRST_PASS_MARK;
            pend_disc_reg <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                bit_pos_reg   <= bit_pos_next;
                found_id_reg  <= found_id_next;
                last_disc_reg <= last_disc_next;
                pend_disc_reg <= pend_disc_next;
                active_reg    <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bit_pos_reg < POS_W'(ROM_BITS)))
        else $error("bit position beyond identifier during a pass");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (result_next.status == ST_DONE)) |=> !active_reg)
        else $error("pass still active after completion");

    a_finished_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.search_finished) |->
            ((result_reg.status == ST_DONE) && (result_reg.next_discrepancy == '0)))
        else $error("finished flag without completed last pass");

endmodule
`default_nettype wire

>>> src/onewire_rom_search_step.sv
`default_nettype none
// Channel   Handshake        Payload     Transaction when
// item      push / full      ors_in_t    push && !full
// result    empty / pop      ors_out_t   pop && !empty
//
// One transaction per cycle in each direction while full or empty does not stall it;
// every item gives one result. An item is decoded into a two-entry op queue,
// then the search state update loads the result register.
// rst_n clears the pass state, the op queue and the result valid flag asynchronously.
// A stalled result holds the back end; the op queue absorbs up to two items.
module onewire_rom_search_step #(
    parameter int ROM_BITS = ors_pkg::ROM_BITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire ors_pkg::ors_in_t item,
    output logic                  empty,
    input  wire logic             pop,
    output ors_pkg::ors_out_t     result
);
    import ors_pkg::*;

    ors_qwr_t q_wr;
    logic     q_rd;
    logic     q_empty;
    op_t      q_op;

    ors_front u_front (
        .push (push),
        .full (full),
        .item (item),
        .wr   (q_wr)
    );

    ors_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .rd_en (q_rd),
        .full  (full),
        .empty (q_empty),
        .rd_op (q_op)
    );

    ors_back #(
        .ROM_BITS (ROM_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (q_op),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
`default_nettype wire
